// ===== hdl/vmi_pkg.sv =====
package vmi_pkg;

    // Default table geometry.
    localparam int PHI_BINS_DEF = 32;
    localparam int VZ_BINS_DEF  = 16;

    // Ten moments per cell, fixed by the algorithm.
    localparam int COMPONENTS = 10;
    localparam int COMP_W     = 4;

    // Input field widths.
    localparam int PHI_W   = 5;
    localparam int VZ_W    = 4;
    localparam int ENTRY_W = 16;
    localparam int DENS_W  = 32;

    // Wide enough to compare bin indices against any bin count in range.
    localparam int BIN_CMP_W = 9;

    // Configuration registers.
    localparam int CFG_DATA_W       = 24;
    localparam int CFG_IDX_W        = 1;
    localparam int VZ_USED_W        = 5;
    localparam int SCALE_W          = 24;
    localparam int VZ_USED_RESET    = 16;
    localparam int SCALE_RESET      = 16384;
    localparam logic [CFG_IDX_W-1:0] CFG_VZ_BINS_USED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENT_SCALE = 1'b1;

    // Operation codes carried on the input tuser.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Result width.
    localparam int MOMENT_W = 32;

endpackage

// ===== hdl/velocity_moment_integrator.sv =====
// Channel     | Signals                    | Word contents (lowest bit first)
// ------------+----------------------------+---------------------------------------------
// s_axis      | tvalid tready tdata tuser  | tdata: phi_bin, vz_bin, component_sel,
//             | tlast                      |   table_entry, density_sample; tuser: operation;
//             |                            |   tlast: last_sample
// m_axis      | tvalid tready tdata tuser  | tdata: moment_value; tuser: component_index,
//             | tlast                      |   negative_seen; tlast: last_result
// cfg         | i_cfg_we i_cfg_index       | 0: vz_bins_used, 1: moment_scale
//             | i_cfg_data                 |
//
// A table load writes the table directly. A density sample makes 10 table reads through the
// single table port, then lets the multiply and add drain; a sample outside the used bins
// skips the reads. A last sample then runs the scale sequence for each moment in the shared
// multiplier, and m_axis_tready can hold a result back.
// Reset is synchronous, active low, and clears sums, flag and registers; the table is not
// cleared. The input is not ready while a word is being worked on.
module velocity_moment_integrator #(
    parameter int PHI_BINS = vmi_pkg::PHI_BINS_DEF,
    parameter int VZ_BINS  = vmi_pkg::VZ_BINS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input words.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // phi_bin[4:0], vz_bin[8:5], component_sel[12:9], table_entry[28:13],
    // density_sample[60:29], zero fill[63:61]
    input  logic [63:0]                          s_axis_tdata,
    // operation[0]
    input  logic                                 s_axis_tuser,
    input  logic                                 s_axis_tlast,
    // Result words.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // moment_value[31:0]
    output logic [31:0]                          m_axis_tdata,
    // component_index[3:0], negative_seen[4]
    output logic [4:0]                           m_axis_tuser,
    output logic                                 m_axis_tlast,
    // Configuration writes.
    input  logic                                 i_cfg_we,
    input  logic [vmi_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [vmi_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int PW       = (PHI_BINS > 1) ? $clog2(PHI_BINS) : 1;
    localparam int VW       = (VZ_BINS > 1) ? $clog2(VZ_BINS) : 1;
    localparam int AW       = vmi_pkg::COMP_W + PW + VW;
    localparam int TBL_DEPTH = vmi_pkg::COMPONENTS * (1 << (PW + VW));
    localparam int CW       = vmi_pkg::BIN_CMP_W;
    localparam int KW       = vmi_pkg::COMP_W;
    localparam logic [KW-1:0] LAST_K = KW'(vmi_pkg::COMPONENTS - 1);
    localparam logic [CW-1:0] PHI_LIM = CW'(PHI_BINS);
    localparam logic [CW-1:0] VZ_LIM  = CW'(VZ_BINS);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ACC   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_ABS   = 3'd3;
    localparam logic [2:0] ST_MLO   = 3'd4;
    localparam logic [2:0] ST_MHI   = 3'd5;
    localparam logic [2:0] ST_SUM   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    // Registers.
    logic [2:0]                          r_state;
    logic [KW-1:0]                       r_k;
    logic [vmi_pkg::VZ_USED_W-1:0]       r_vz_bins_used;
    logic [vmi_pkg::SCALE_W-1:0]         r_moment_scale;
    logic [PW-1:0]                       r_phi_idx;
    logic [VW-1:0]                       r_vz_idx;
    logic signed [vmi_pkg::DENS_W-1:0]   r_dens;
    logic                                r_half;
    logic                                r_last;
    logic                                r_negflag;
    logic signed [63:0]                  r_sums [vmi_pkg::COMPONENTS];
    logic [vmi_pkg::ENTRY_W-1:0]         r_table [TBL_DEPTH];
    logic signed [vmi_pkg::ENTRY_W-1:0]  r_rd;
    logic                                r_v1;
    logic [KW-1:0]                       r_k1;
    logic                                r_v2;
    logic [KW-1:0]                       r_k2;
    logic [56:0]                         r_prod;
    logic [63:0]                         r_mag;
    logic                                r_sneg;
    logic [56:0]                         r_low;
    logic [51:0]                         r_q;
    logic                                r_m_valid;
    logic [31:0]                         r_m_data;
    logic [4:0]                          r_m_user;
    logic                                r_m_last;

    // Input field decode.
    logic [vmi_pkg::PHI_W-1:0]           in_phi;
    logic [vmi_pkg::VZ_W-1:0]            in_vz;
    logic [KW-1:0]                       in_comp;
    logic [vmi_pkg::ENTRY_W-1:0]         in_entry;
    logic signed [vmi_pkg::DENS_W-1:0]   in_dens;
    logic [CW-1:0]                       phi_ext;
    logic [CW-1:0]                       vz_ext;
    logic [CW-1:0]                       n_bins;
    logic                                s_fire;
    logic                                load_ok;
    logic                                contrib;
    logic                                half;
    logic [AW-1:0]                       wr_addr;
    logic [AW-1:0]                       rd_addr;

    assign in_phi   = s_axis_tdata[4:0];
    assign in_vz    = s_axis_tdata[8:5];
    assign in_comp  = s_axis_tdata[12:9];
    assign in_entry = s_axis_tdata[28:13];
    assign in_dens  = s_axis_tdata[60:29];
    assign phi_ext  = CW'(in_phi);
    assign vz_ext   = CW'(in_vz);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Effective bin count: zero reads as one, values past the table as the table size.
    always_comb begin
        if (r_vz_bins_used == '0) begin
            n_bins = CW'(1);
        end else if (CW'(r_vz_bins_used) > VZ_LIM) begin
            n_bins = VZ_LIM;
        end else begin
            n_bins = CW'(r_vz_bins_used);
        end
    end

    assign load_ok = (in_comp < KW'(vmi_pkg::COMPONENTS)) && (phi_ext < PHI_LIM)
                     && (vz_ext < VZ_LIM);
    assign contrib = (phi_ext < PHI_LIM) && (vz_ext < n_bins);
    assign half    = (n_bins > CW'(1)) && ((vz_ext == '0) || (vz_ext == n_bins - CW'(1)));
    assign wr_addr = {in_comp, phi_ext[PW-1:0], vz_ext[VW-1:0]};
    assign rd_addr = {r_k, r_phi_idx, r_vz_idx};

    // Direction table: one write port for loads, one registered read port.
    always_ff @(posedge i_clk) begin
        if (s_fire && (s_axis_tuser == vmi_pkg::OP_LOAD) && load_ok) begin
            r_table[wr_addr] <= in_entry;
        end
        r_rd <= r_table[rd_addr];
    end

    // Shared multiplier: density times table entry, or magnitude half times scale.
    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [57:0] mul_p;

    always_comb begin
        unique case (r_state)
            ST_MLO: begin
                mul_a = {1'b0, r_mag[31:0]};
                mul_b = {1'b0, r_moment_scale};
            end
            ST_MHI: begin
                mul_a = {1'b0, r_mag[63:32]};
                mul_b = {1'b0, r_moment_scale};
            end
            default: begin
                mul_a = {r_dens[31], r_dens};
                mul_b = {{9{r_rd[15]}}, r_rd};
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Weighted product and saturating accumulate.
    logic signed [48:0] p_acc;
    logic signed [64:0] acc_sum;
    logic signed [63:0] acc_sat;

    assign p_acc   = r_half ? {r_prod[47], r_prod[47:0]} : {r_prod[47:0], 1'b0};
    assign acc_sum = {r_sums[r_k2][63], r_sums[r_k2]} + {{16{p_acc[48]}}, p_acc};

    always_comb begin
        if (acc_sum[64] != acc_sum[63]) begin
            acc_sat = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            acc_sat = acc_sum[63:0];
        end
    end

    // Rounded, saturated result of the scale sequence.
    logic        out_free;
    logic [31:0] res_val;

    assign out_free = !r_m_valid || m_axis_tready;

    always_comb begin
        if (r_sneg) begin
            res_val = (r_q > 52'h0_0000_8000_0000) ? 32'h8000_0000 : (32'd0 - r_q[31:0]);
        end else begin
            res_val = (r_q > 52'h0_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : r_q[31:0];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vz_bins_used <= vmi_pkg::VZ_USED_W'(vmi_pkg::VZ_USED_RESET);
            r_moment_scale <= vmi_pkg::SCALE_W'(vmi_pkg::SCALE_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                vmi_pkg::CFG_VZ_BINS_USED: r_vz_bins_used <= i_cfg_data[vmi_pkg::VZ_USED_W-1:0];
                vmi_pkg::CFG_MOMENT_SCALE: r_moment_scale <= i_cfg_data[vmi_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_phi_idx <= phi_ext[PW-1:0];
            r_vz_idx  <= vz_ext[VW-1:0];
            r_dens    <= in_dens;
            r_half    <= half;
            r_last    <= s_axis_tlast;
        end
        r_k1 <= r_k;
        r_k2 <= r_k1;
        if (r_v1 || (r_state == ST_MLO) || (r_state == ST_MHI)) begin
            r_prod <= mul_p[56:0];
        end
        if (r_state == ST_ABS) begin
            r_sneg <= r_sums[r_k][63];
            r_mag  <= r_sums[r_k][63] ? (64'd0 - r_sums[r_k]) : r_sums[r_k];
        end
        if (r_state == ST_MHI) begin
            r_low <= r_prod + 57'h0_0010_0000_0000;
        end
        if (r_state == ST_SUM) begin
            r_q <= 52'((r_prod + 57'(r_low[56:32])) >> 5);
        end
        if ((r_state == ST_OUT) && out_free) begin
            r_m_data <= res_val;
            r_m_user <= {r_negflag, r_k};
            r_m_last <= (r_k == LAST_K);
        end
    end

    // Sequencer, accumulators and output handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_k       <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_negflag <= 1'b0;
            r_m_valid <= 1'b0;
            for (int i = 0; i < vmi_pkg::COMPONENTS; i++) begin
                r_sums[i] <= '0;
            end
        end else begin
            r_v1 <= (r_state == ST_ACC);
            r_v2 <= r_v1;
            if (r_v2) begin
                r_sums[r_k2] <= acc_sat;
            end
            // The output state reloads the result register itself when it is free.
            if (r_m_valid && m_axis_tready && (r_state != ST_OUT)) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_fire && (s_axis_tuser == vmi_pkg::OP_SAMPLE)) begin
                        r_negflag <= r_negflag | in_dens[31];
                        r_k       <= '0;
                        if (contrib) begin
                            r_state <= ST_ACC;
                        end else if (s_axis_tlast) begin
                            r_state <= ST_ABS;
                        end
                    end
                end
                ST_ACC: begin
                    if (r_k == LAST_K) begin
                        r_k     <= '0;
                        r_state <= ST_DRAIN;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!r_v1) begin
                        r_state <= r_last ? ST_ABS : ST_IDLE;
                    end
                end
                ST_ABS: r_state <= ST_MLO;
                ST_MLO: r_state <= ST_MHI;
                ST_MHI: r_state <= ST_SUM;
                ST_SUM: r_state <= ST_OUT;
                ST_OUT: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        if (r_k == LAST_K) begin
                            r_k       <= '0;
                            r_negflag <= 1'b0;
                            r_state   <= ST_IDLE;
                            for (int i = 0; i < vmi_pkg::COMPONENTS; i++) begin
                                r_sums[i] <= '0;
                            end
                        end else begin
                            r_k     <= r_k + KW'(1);
                            r_state <= ST_ABS;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tlast  = r_m_last;

    // Table read results only flow while a sample is being accumulated.
    a_pipe_in_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> ((r_state == ST_ACC) || (r_state == ST_DRAIN)))
        else $error("table read pipeline active outside accumulation");

    // The closing result of a cell always carries the last moment index.
    a_last_is_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[3:0] == LAST_K))
        else $error("last result with wrong component index");

    // Emitting the last moment returns to idle with the flag cleared.
    a_cell_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_OUT) && out_free && (r_k == LAST_K))
        |=> ((r_state == ST_IDLE) && !r_negflag && m_axis_tvalid && m_axis_tlast))
        else $error("cell did not close cleanly");

    // A negative sample always raises the flag for its cell.
    a_neg_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && (s_axis_tuser == vmi_pkg::OP_SAMPLE) && in_dens[31]) |=> r_negflag)
        else $error("negative sample did not set the flag");

endmodule
